>>> src/fpd_pkg.sv
//------------------------------------------------------------------------------
// fpd_pkg
// shared types, constants and helpers of the factor product decomposition block
//------------------------------------------------------------------------------
`default_nettype none
package fpd_pkg;
	localparam int unsigned MaxFactorsDefault = 8;
	localparam int unsigned QOne = 32'h0001_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_DIV,
		ST_ACC,
		ST_EFF,
		ST_OUT
	} fpd_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // store the accepted pair
		logic sum_clr;    // clear accumulator, start of a factor
		logic prod_init;  // product back to one, start of a subset
		logic prod_step;  // multiply in one factor
		logic div_start;  // start weighting divide
		logic acc;        // add weighted term
		logic eff_mul;    // form the effect
	} fpd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic eff_done;
	} fpd_sts_t;

	// n choose k from a constant pascal triangle, no divide
	function automatic logic [9:0] binom(input logic [3:0] n, input logic [3:0] k);
		logic [9:0] pascal [13][13];
		for (int a = 0; a < 13; a++) begin
			for (int b = 0; b < 13; b++) begin
				if (b == 0)
					pascal[a][b] = 10'd1;
				else if (a == 0)
					pascal[a][b] = 10'd0;
				else
					pascal[a][b] = 10'(pascal[a-1][b-1] + pascal[a-1][b]);
			end
		end
		if (n > 4'd12 || k > 4'd12)
			return 10'd0;
		return pascal[n][k];
	endfunction
endpackage
`default_nettype wire

>>> src/fpd_datapath.sv
//------------------------------------------------------------------------------
// fpd_datapath
// factor stores, subset product multiplier, serial divider, accumulator, effect
//------------------------------------------------------------------------------
`default_nettype none
module fpd_datapath #(
	parameter int unsigned MAX_FACTORS = 8,
	parameter int unsigned IDX_W = 3
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire fpd_pkg::fpd_cmd_t           cmd,
	output fpd_pkg::fpd_sts_t                sts,
	input  wire logic [IDX_W-1:0]            wr_idx,
	input  wire logic signed [31:0]          x_in,
	input  wire logic signed [31:0]          y_in,
	input  wire logic [IDX_W-1:0]            rd_idx,
	input  wire logic                        use_x,
	input  wire logic [IDX_W-1:0]            k_idx,
	input  wire logic [3:0]                  p,
	input  wire logic [3:0]                  subset_size,
	output logic signed [47:0]               effect_q
);
	import fpd_pkg::*;

	logic signed [31:0] x_mem [MAX_FACTORS];
	logic signed [31:0] y_mem [MAX_FACTORS];
	logic signed [31:0] prod_q;
	logic signed [47:0] sum_q;
	logic [31:0] quo_q;
	logic [13:0] div_q;
	logic [5:0] div_cnt_q;
	logic div_busy_q;
	logic neg_q;
	logic [1:0] eff_cnt_q;
	logic signed [80:0] eprod;
	logic signed [57:0] eff_lo_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_mem[wr_idx] <= x_in;
			y_mem[wr_idx] <= y_in;
		end
	end

	// q16 product, rounded magnitude, saturated
	logic signed [31:0] opnd;
	logic signed [63:0] full;
	logic [63:0] mag;
	logic [48:0] rmag;
	logic pneg;
	always_comb begin
		opnd = use_x ? x_mem[rd_idx] : y_mem[rd_idx];
		full = 64'(prod_q) * 64'(opnd);
		pneg = full[63];
		mag = pneg ? 64'(-full) : full;
		rmag = 49'(mag[63:16]) + 49'(mag[15]);
	end

	always_ff @(posedge clk) begin
		if (cmd.prod_init)
			prod_q <= 32'(QOne);
		else if (cmd.prod_step) begin
			if (!pneg)
				prod_q <= (rmag > 49'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(rmag);
			else
				prod_q <= (rmag > 49'h8000_0000) ? 32'sh8000_0000 : 32'(-rmag);
		end
	end

	// weighting divide: restoring, one bit a cycle, (|prod| + d/2) / d
	logic [13:0] dv;
	always_comb begin
		dv = 14'(p) * 14'(binom(p - 4'd1, subset_size));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q <= 6'd34;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - 6'd1;
			if (div_cnt_q == 6'd1)
				div_busy_q <= 1'b0;
		end
	end

	logic [32:0] pmag;
	assign pmag = prod_q[31] ? 33'(-34'(prod_q)) : 33'(prod_q);

	logic [33:0] numer;
	assign numer = 34'(pmag) + 34'(dv >> 1);

	logic [33:0] rem34_q;
	logic [33:0] num34_q;
	logic [34:0] t34;
	assign t34 = {rem34_q, num34_q[33]};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num34_q <= numer;
			rem34_q <= '0;
			quo_q <= '0;
			div_q <= dv;
			neg_q <= prod_q[31];
		end else if (div_busy_q && div_cnt_q != 6'd0) begin
			num34_q <= {num34_q[32:0], 1'b0};
			if (t34 >= 35'(div_q)) begin
				rem34_q <= 34'(t34 - 35'(div_q));
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem34_q <= 34'(t34);
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
	assign sts = '{div_done: div_busy_q && div_cnt_q == 6'd1, eff_done: eff_cnt_q == 2'd1};

	// accumulate with 48-bit saturation
	logic signed [49:0] asum;
	assign asum = 50'(sum_q) + (neg_q ? -50'(quo_q) : 50'(quo_q));
	always_ff @(posedge clk) begin
		if (cmd.sum_clr)
			sum_q <= '0;
		else if (cmd.acc) begin
			if (asum > 50'sh7FFF_FFFF_FFFF)
				sum_q <= 48'sh7FFF_FFFF_FFFF;
			else if (asum < -50'sh8000_0000_0000)
				sum_q <= 48'sh8000_0000_0000;
			else
				sum_q <= 48'(asum);
		end
	end

	// effect: sum * (y_k - x_k) from two partial products, then round
	logic signed [32:0] diff;
	logic signed [24:0] sum_lo;
	logic signed [23:0] sum_hi;
	logic signed [57:0] plo;
	logic signed [56:0] phi;
	logic signed [80:0] emag;
	logic [64:0] erm;
	logic eneg;
	assign diff = 33'(y_mem[k_idx]) - 33'(x_mem[k_idx]);
	assign sum_lo = $signed({1'b0, sum_q[23:0]});
	assign sum_hi = sum_q[47:24];
	assign plo = 58'(sum_lo) * 58'(diff);
	assign phi = 57'(sum_hi) * 57'(diff);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			eff_cnt_q <= '0;
		else if (cmd.eff_mul)
			eff_cnt_q <= 2'd3;
		else if (eff_cnt_q != 2'd0)
			eff_cnt_q <= eff_cnt_q - 2'd1;
	end
	always_ff @(posedge clk) begin
		if (eff_cnt_q == 2'd3)
			eff_lo_q <= plo;
		else if (eff_cnt_q == 2'd2)
			eprod <= (81'(phi) <<< 24) + 81'(eff_lo_q);
	end
	always_comb begin
		eneg = eprod[80];
		emag = eneg ? -eprod : eprod;
		erm = 65'(emag[79:16]) + 65'(emag[15]);
	end
	always_ff @(posedge clk) begin
		if (eff_cnt_q == 2'd1) begin
			if (!eneg)
				effect_q <= (erm > 65'h7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF : 48'(erm);
			else
				effect_q <= (erm > 65'h8000_0000_0000) ? 48'sh8000_0000_0000 : 48'(-erm);
		end
	end
endmodule
`default_nettype wire

>>> src/fpd_control.sv
//------------------------------------------------------------------------------
// fpd_control
// row loading, subset and factor sequencing, result handshake
//------------------------------------------------------------------------------
`default_nettype none
module fpd_control #(
	parameter int unsigned MAX_FACTORS = 8,
	parameter int unsigned IDX_W = 3
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [3:0]          num_factors,
	input  wire logic                cfg_wr,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [IDX_W-1:0]         k_q,
	output logic                     last_q,
	output fpd_pkg::fpd_cmd_t        cmd,
	input  wire fpd_pkg::fpd_sts_t   sts,
	output logic [IDX_W-1:0]         wr_idx,
	output logic [IDX_W-1:0]         rd_idx,
	output logic                     use_x,
	output logic [3:0]               p,
	output logic [3:0]               subset_size
);
	import fpd_pkg::*;

	localparam int unsigned SW = (MAX_FACTORS > 1) ? MAX_FACTORS - 1 : 1;

	fpd_state_t state_q, state_d;
	logic [3:0] load_q;
	logic [SW-1:0] subset_q;
	logic [3:0] i_q;
	logic [3:0] bit_q;
	logic out_pend_q;

	always_comb begin
		if (num_factors == 4'd0)
			p = 4'd1;
		else if (32'(num_factors) > MAX_FACTORS)
			p = 4'(MAX_FACTORS);
		else
			p = num_factors;
	end

	logic [SW:0] subset_ext;
	assign subset_ext = {1'b0, subset_q};
	assign wr_idx = load_q[IDX_W-1:0];
	assign rd_idx = i_q[IDX_W-1:0];
	assign use_x = subset_ext[bit_q[IDX_W-1:0]];
	always_comb begin
		subset_size = '0;
		for (int b = 0; b < SW; b++)
			subset_size = subset_size + 4'(subset_q[b]);
	end

	logic last_sub;
	assign last_sub = 32'(subset_q) == (32'd1 << (p - 4'd1)) - 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = state_q == ST_IDLE;
		out_valid = out_pend_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (load_q + 4'd1 >= p) begin
						state_d = ST_PROD;
						cmd.sum_clr = 1'b1;
						cmd.prod_init = 1'b1;
					end
				end
			end
			ST_PROD: begin
				if (i_q >= p)
					begin
						state_d = ST_DIV;
						cmd.div_start = 1'b1;
					end
				else if (i_q[IDX_W-1:0] != k_q)
					cmd.prod_step = 1'b1;
			end
			ST_DIV: begin
				if (sts.div_done)
					state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				cmd.prod_init = 1'b1;
				state_d = last_sub ? ST_EFF : ST_PROD;
				if (last_sub)
					cmd.eff_mul = 1'b1;
			end
			ST_EFF: begin
				if (sts.eff_done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_valid && out_ready) begin
					if (last_q)
						state_d = ST_IDLE;
					else begin
						state_d = ST_PROD;
						cmd.sum_clr = 1'b1;
						cmd.prod_init = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
			subset_q <= '0;
			i_q <= '0;
			bit_q <= '0;
			k_q <= '0;
			out_pend_q <= 1'b0;
		end else begin
			if (cfg_wr)
				load_q <= '0;
			else if (cmd.load)
				load_q <= (load_q + 4'd1 >= p) ? 4'd0 : load_q + 4'd1;
			if (cmd.load) begin
				subset_q <= '0;
				i_q <= '0;
				bit_q <= '0;
				k_q <= '0;
			end
			if (state_q == ST_PROD && i_q < p) begin
				i_q <= i_q + 4'd1;
				if (i_q[IDX_W-1:0] != k_q)
					bit_q <= bit_q + 4'd1;
			end
			if (state_q == ST_ACC) begin
				i_q <= '0;
				bit_q <= '0;
				subset_q <= last_sub ? '0 : subset_q + SW'(1);
			end
			if (sts.eff_done)
				out_pend_q <= 1'b1;
			if (state_q == ST_OUT && out_ready) begin
				out_pend_q <= 1'b0;
				k_q <= k_q + IDX_W'(1);
			end
		end
	end
	assign last_q = 4'(k_q) == p - 4'd1;
endmodule
`default_nettype wire

>>> src/factor_product_decomposition.sv
//------------------------------------------------------------------------------
// factor_product_decomposition
// multiplicative factor decomposition of one row of (x, y) factor pairs
//------------------------------------------------------------------------------
// a row is num_factors pairs, one per input transaction; once the last pair is
// in, one effect per factor comes out in factor order, last set on the final
// one. effect k is (y_k - x_k) times the weighted sum over the 2^(P-1) subsets
// of the other factors. each subset goes through the q16 product multiplier,
// the bit-serial weighting divider and an accumulate step; each effect is then
// formed and handed out through its output handshake. the divider sets the
// pace. input is taken only while no row is in flight. a config write drops
// any partial row.
//------------------------------------------------------------------------------
`default_nettype none
module factor_product_decomposition #(
	parameter int unsigned MAX_FACTORS = fpd_pkg::MaxFactorsDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [1:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] x_value,
	input  wire logic signed [31:0] y_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              factor_index,
	output logic signed [47:0]      effect,
	output logic                    last
);
	import fpd_pkg::*;

	localparam int unsigned IDX_W = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;

	logic [3:0] num_factors_q;
	logic cfg_wr;
	fpd_cmd_t cmd;
	fpd_sts_t sts;
	logic [IDX_W-1:0] wr_idx, rd_idx, k_idx;
	logic use_x;
	logic [3:0] p, subset_size;

	// config register, only num_factors at offset zero
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && paddr == 2'd0;
	assign prdata = (paddr == 2'd0) ? {28'd0, num_factors_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			num_factors_q <= 4'd2;
		else if (cfg_wr)
			num_factors_q <= pwdata[3:0];
	end

	fpd_control #(.MAX_FACTORS(MAX_FACTORS), .IDX_W(IDX_W)) u_ctrl (
		.clk, .arst_n, .num_factors(num_factors_q), .cfg_wr,
		.in_valid, .in_ready, .out_valid, .out_ready,
		.k_q(k_idx), .last_q(last), .cmd, .sts,
		.wr_idx, .rd_idx, .use_x, .p, .subset_size
	);

	fpd_datapath #(.MAX_FACTORS(MAX_FACTORS), .IDX_W(IDX_W)) u_dp (
		.clk, .arst_n, .cmd, .sts, .wr_idx,
		.x_in(x_value), .y_in(y_value), .rd_idx, .use_x, .k_idx, .p,
		.subset_size, .effect_q(effect)
	);

	assign factor_index = 3'(k_idx);
endmodule
`default_nettype wire

>>> src/fpd_checker.sv
//------------------------------------------------------------------------------
// fpd_checker
// port-level checks of the decomposition block
//------------------------------------------------------------------------------
`default_nettype none
module fpd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  factor_index,
	input wire logic [47:0] effect,
	input wire logic        last
);
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken during output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(effect))
		else $error("result dropped");
	a_idx_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> factor_index == $past(factor_index) + 3'd1)
		else $error("index skipped");
endmodule

bind factor_product_decomposition fpd_checker u_chk (
	.clk, .arst_n, .in_ready, .out_valid, .out_ready, .factor_index, .effect, .last
);
`default_nettype wire

>>> tb/sv/tb_top.sv
//------------------------------------------------------------------------------
// tb_top
// self-checking bench for the factor product decomposition block
//------------------------------------------------------------------------------
// rows of (x, y) pairs go in through a valid/ready driver fed from a queue; an
// in-bench predictor works out the per-factor effects of every completed row
// and a monitor compares each output transaction with the oldest expected one.
// the factor count is changed over the run through the apb port while idle.
//------------------------------------------------------------------------------
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NumFactorsMax = 8;
	localparam logic [1:0] AddrNumFactors = 2'd0;
	localparam longint unsigned Q16Max = 64'd2147483647;
	localparam longint unsigned S48Max = 64'd140737488355327;
	localparam longint unsigned CycleLimit = 64'd3000000;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} factor_pair_t;

	typedef struct packed {
		logic [2:0]         index;
		logic signed [47:0] eff;
		logic               last;
	} factor_effect_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid, in_ready;
	logic signed [31:0] x_value, y_value;
	logic out_valid, out_ready;
	logic [2:0] factor_index;
	logic signed [47:0] effect;
	logic last;

	factor_product_decomposition u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.x_value(x_value), .y_value(y_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.factor_index(factor_index), .effect(effect), .last(last)
	);

	// clock, 20 ns period
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	factor_pair_t   pair_queue[$];
	factor_effect_t effect_queue[$];
	int unsigned    error_count = 0;
	longint unsigned cycle_count = 0;

	// handshake counts, bumped at the accepting edge
	int unsigned in_accepts = 0;
	int unsigned out_accepts = 0;

	// predictor state
	logic signed [31:0] row_x[NumFactorsMax];
	logic signed [31:0] row_y[NumFactorsMax];
	int unsigned row_fill = 0;
	logic [3:0]  factor_count = 4'd2;

	// signed value from sign and magnitude, clipped to the given positive max
	function automatic longint clip_mag(bit neg, longint unsigned mag,
			longint unsigned pos_max);
		if (neg) begin
			if (mag > pos_max + 1)
				mag = pos_max + 1;
			return -longint'(mag);
		end
		if (mag > pos_max)
			mag = pos_max;
		return longint'(mag);
	endfunction

	function automatic longint unsigned abs_u(longint v);
		return v < 0 ? 64'd0 - longint'(v) : longint'(v);
	endfunction

	// q16 multiply: magnitude rounded half away from zero, then saturated
	function automatic longint q16_mul(longint a, longint b, longint unsigned pos_max);
		bit neg;
		longint unsigned ma, mb, m;
		neg = (a < 0) != (b < 0);
		ma = abs_u(a);
		mb = abs_u(b);
		if (ma != 0 && mb > 64'hFFFF_FFFF_FFFF_FFFF / ma)
			return clip_mag(neg, 64'hFFFF_FFFF_FFFF_FFFF, pos_max);
		m = ma * mb;
		m = (m >> 16) + ((m >> 15) & 1);
		return clip_mag(neg, m, pos_max);
	endfunction

	function automatic longint unsigned choose(int unsigned n, int unsigned k);
		longint unsigned c;
		c = 1;
		for (int unsigned i = 1; i <= k; i++)
			c = c * (n - i + 1) / i;
		return c;
	endfunction

	// weighted subset sum for factor k over a row of p factors
	function automatic longint subset_sum(int unsigned p, int unsigned k);
		longint acc, prod;
		longint unsigned dv, q;
		int unsigned bitpos, size;
		acc = 0;
		for (int unsigned s = 0; s < (1 << (p - 1)); s++) begin
			prod = 65536;
			bitpos = 0;
			size = 0;
			for (int unsigned i = 0; i < p; i++) begin
				if (i != k) begin
					if ((s >> bitpos) & 1) begin
						prod = q16_mul(prod, row_x[i], Q16Max);
						size++;
					end else begin
						prod = q16_mul(prod, row_y[i], Q16Max);
					end
					bitpos++;
				end
			end
			dv = p * choose(p - 1, size);
			q = (abs_u(prod) + dv / 2) / dv;
			acc = acc + (prod < 0 ? -longint'(q) : longint'(q));
			acc = clip_mag(acc < 0, abs_u(acc), S48Max);
		end
		return acc;
	endfunction

	// take one accepted pair, push the row's effects once it completes
	task automatic predict_effects(factor_pair_t pr);
		int unsigned p;
		longint s, d, e;
		factor_effect_t fe;
		p = factor_count == 0 ? 1 : (factor_count > NumFactorsMax ? NumFactorsMax
			: factor_count);
		if (row_fill >= p)
			row_fill = 0;
		row_x[row_fill] = pr.x;
		row_y[row_fill] = pr.y;
		row_fill++;
		if (row_fill < p)
			return;
		row_fill = 0;
		for (int unsigned k = 0; k < p; k++) begin
			s = subset_sum(p, k);
			d = longint'(row_y[k]) - longint'(row_x[k]);
			e = q16_mul(s, d, S48Max);
			fe.index = 3'(k);
			fe.eff = e[47:0];
			fe.last = (k == p - 1);
			effect_queue.push_back(fe);
		end
	endtask

	// driver: one pair per transaction with a random gap before each
	int unsigned send_gap = 0;
	int unsigned in_seen = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_accepts != in_seen) begin
				in_seen = in_accepts;
				in_valid <= 1'b0;
				send_gap = $urandom_range(0, 7);
			end else if (!in_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pair_queue.size() > 0) begin
					factor_pair_t pr;
					pr = pair_queue.pop_front();
					x_value <= pr.x;
					y_value <= pr.y;
					in_valid <= 1'b1;
				end
			end
		end
	end

	// input acceptance feeds the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			predict_effects('{x: x_value, y: y_value});
			in_accepts++;
		end
	end

	// output stall pattern, redrawn after each transaction
	int unsigned stall_left = 0;
	int unsigned out_seen = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_accepts != out_seen) begin
				out_seen = out_accepts;
				stall_left = $urandom_range(0, 7);
				if (stall_left > 0)
					out_ready <= 1'b0;
			end else if (!out_ready) begin
				if (stall_left > 0)
					stall_left--;
				if (stall_left == 0)
					out_ready <= 1'b1;
			end
		end
	end

	// monitor: compare each output transaction with the oldest expectation
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && out_valid && out_ready) begin
			out_accepts++;
			if (effect_queue.size() == 0) begin
				$display("%0t: unexpected effect index %0d value %0d", $time,
					factor_index, effect);
				error_count++;
			end else begin
				factor_effect_t ex;
				ex = effect_queue.pop_front();
				if (ex.index !== factor_index) begin
					$display("%0t: factor_index expected %0d actual %0d", $time,
						ex.index, factor_index);
					error_count++;
				end
				if (ex.eff !== effect) begin
					$display("%0t: effect expected %0d actual %0d", $time,
						ex.eff, effect);
					error_count++;
				end
				if (ex.last !== last) begin
					$display("%0t: last expected %0d actual %0d", $time,
						ex.last, last);
					error_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (cycle_count > CycleLimit) begin
			$display("FAIL factor_product_decomposition");
			$finish;
		end
	end

	// apb write: setup then access, register taken on the access edge
	task automatic write_factor_count(logic [3:0] n);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= AddrNumFactors;
		pwdata <= 32'(n);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		factor_count = n;
		row_fill = 0;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// hold until the driver is empty and all effects have arrived
	task automatic wait_drained();
		while (pair_queue.size() > 0 || in_valid || effect_queue.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $urandom();
			default: return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
		endcase
	endfunction

	task automatic queue_row(int unsigned p, bit wild);
		factor_pair_t pr;
		for (int unsigned i = 0; i < p; i++) begin
			pr.x = wild ? pick_value() : $urandom();
			pr.y = wild ? pick_value() : $urandom();
			pair_queue.push_back(pr);
		end
	endtask

	logic [3:0] settings[] = '{4'd1, 4'd8, 4'd0, 4'd3, 4'd15, 4'd2, 4'd5, 4'd4};

	initial begin
		int unsigned p;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		x_value = '0;
		y_value = '0;
		out_ready = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset setting of two factors, field extremes and small values
		pair_queue.push_back('{x: 32'sh8000_0000, y: 32'sh7FFF_FFFF});
		pair_queue.push_back('{x: 32'sh7FFF_FFFF, y: 32'sh8000_0000});
		pair_queue.push_back('{x: 32'sh0001_0000, y: 32'sh0002_0000});
		pair_queue.push_back('{x: 32'sh0003_0000, y: 32'shFFFF_0000});
		pair_queue.push_back('{x: 32'sh0000_0000, y: 32'sh0000_0000});
		pair_queue.push_back('{x: 32'shFFFF_FFFF, y: 32'sh0000_0001});
		// a partial row, dropped by the next register write
		pair_queue.push_back('{x: 32'sh0005_0000, y: 32'sh0006_0000});
		wait_drained();

		// single factor: effect is y - x, extremes included
		write_factor_count(4'd1);
		pair_queue.push_back('{x: 32'sh8000_0000, y: 32'sh7FFF_FFFF});
		pair_queue.push_back('{x: 32'sh7FFF_FFFF, y: 32'sh8000_0000});
		pair_queue.push_back('{x: 32'sh1234_5678, y: 32'shEDCB_A987});
		wait_drained();

		// saturating row at the largest size
		write_factor_count(4'd8);
		for (int i = 0; i < 8; i++)
			pair_queue.push_back('{x: 32'sh7FFF_FFFF, y: 32'sh8000_0000});
		wait_drained();

		// random phases, each through a new factor count
		foreach (settings[s]) begin
			write_factor_count(settings[s]);
			p = settings[s] == 0 ? 1 : (settings[s] > 8 ? 8 : settings[s]);
			for (int r = 0; r < (p >= 7 ? 2 : 14 / p + 1); r++)
				queue_row(p, $urandom_range(0, 3) != 0);
			// occasional stray partial row
			if (p > 1 && $urandom_range(0, 1))
				queue_row(p - 1, 1'b1);
			wait_drained();
		end

		if (error_count == 0) begin
			$display("PASS factor_product_decomposition");
		end else begin
			$display("FAIL factor_product_decomposition");
		end
		$finish;
	end
endmodule
`default_nettype wire
